FILE: rtl/ccsc_pkg.sv
// Package for the column to span converter.
// Field widths, the default row count and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package ccsc_pkg;

  // field widths
  localparam int unsigned COL_W = 11;
  localparam int unsigned ROW_W = 6;
  localparam int unsigned TOP_W = 7;

  // rows held in the start-column store
  localparam int unsigned ROWS_DEFAULT = 64;

  // sequencer phases: close tops, close bottoms, open tops, open bottoms
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE_TOP,
    ST_CLOSE_BOT,
    ST_OPEN_TOP,
    ST_OPEN_BOT
  } state_e;

endpackage

FILE: rtl/column_to_span_converter_top.sv
// Column to span converter: top level with sequencer, start-column store
// and output register. Depends on ccsc_pkg.
`timescale 1ns / 1ps

// An input column is taken when in_ready_o is high; the block then stays
// busy until the column is fully handled. A five-phase sequencer walks one
// row per cycle (a close step waits while the output register is stalled)
// with separate top and bottom row counters: first it closes rows at the top
// (ascending), then rows at the bottom (descending), each closed row giving
// one span through the output register, then it records this column as the
// start of every newly covered row, one store write per cycle. The last span
// of a column has last_o set; a column that closes nothing gives no span. The
// start-column store is a ROWS-deep memory with a registered read and holds
// no reset value: closing a row that was never opened returns an arbitrary
// start column. Rows at or beyond ROWS are not stored and read as zero.
module column_to_span_converter_top #(
  parameter int unsigned ROWS = ccsc_pkg::ROWS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input column channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ccsc_pkg::COL_W-1:0]   column_i,
  input  logic [ccsc_pkg::TOP_W-1:0]   prev_top_i,
  input  logic [ccsc_pkg::ROW_W-1:0]   prev_bottom_i,
  input  logic [ccsc_pkg::TOP_W-1:0]   cur_top_i,
  input  logic [ccsc_pkg::ROW_W-1:0]   cur_bottom_i,
  // span channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ccsc_pkg::ROW_W-1:0]   span_row_o,
  output logic [ccsc_pkg::COL_W-1:0]   span_first_o,
  output logic [ccsc_pkg::COL_W-1:0]   span_last_col_o,
  output logic                         last_o
);

  localparam int unsigned COL_W = ccsc_pkg::COL_W;
  localparam int unsigned ROW_W = ccsc_pkg::ROW_W;
  localparam int unsigned TOP_W = ccsc_pkg::TOP_W;
  localparam int unsigned AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [TOP_W-1:0] RowsLimit = TOP_W'(ROWS);

  ccsc_pkg::state_e state_q, state_d;

  logic [COL_W-1:0] col_q;
  logic [TOP_W-1:0] t1_q, t1_d, t2_q, t2_d;
  logic [ROW_W-1:0] b1_q, b1_d, b2_q, b2_d;

  logic             out_valid_q;
  logic [ROW_W-1:0] span_row_q;
  logic [COL_W-1:0] span_first_q;
  logic [COL_W-1:0] span_last_q;
  logic             last_q;

  logic             in_fire;
  logic             out_free;
  logic             load;
  logic [ROW_W-1:0] ld_row;
  logic             ld_last;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;

  logic [TOP_W-1:0] t1_nx;
  logic [ROW_W-1:0] b1_nx;

  logic [COL_W-1:0] mem_q [ROWS];

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign t1_nx    = t1_q + TOP_W'(1);
  assign b1_nx    = b1_q - ROW_W'(1);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, row walk and store/output strobes
  always_comb begin
    state_d    = state_q;
    t1_d       = t1_q;
    b1_d       = b1_q;
    t2_d       = t2_q;
    b2_d       = b2_q;
    in_ready_o = 1'b0;
    load       = 1'b0;
    ld_row     = t1_q[ROW_W-1:0];
    ld_last    = 1'b0;
    wr_en      = 1'b0;
    wr_row     = t2_q[ROW_W-1:0];
    unique case (state_q)
      ccsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          t1_d    = prev_top_i;
          b1_d    = prev_bottom_i;
          t2_d    = cur_top_i;
          b2_d    = cur_bottom_i;
          state_d = ccsc_pkg::ST_CLOSE_TOP;
        end
      end
      ccsc_pkg::ST_CLOSE_TOP: begin
        if ((t1_q < t2_q) && (t1_q <= {1'b0, b1_q})) begin
          if (out_free) begin
            load    = 1'b1;
            ld_row  = t1_q[ROW_W-1:0];
            // final if neither loop has another row after this one
            ld_last = !((t1_nx < t2_q) && (t1_nx <= {1'b0, b1_q})) &&
                      !((b1_q > b2_q) && ({1'b0, b1_q} >= t1_nx));
            t1_d    = t1_nx;
          end
        end else begin
          state_d = ccsc_pkg::ST_CLOSE_BOT;
        end
      end
      ccsc_pkg::ST_CLOSE_BOT: begin
        if ((b1_q > b2_q) && ({1'b0, b1_q} >= t1_q)) begin
          if (out_free) begin
            load    = 1'b1;
            ld_row  = b1_q;
            ld_last = !((b1_nx > b2_q) && ({1'b0, b1_nx} >= t1_q));
            b1_d    = b1_nx;
          end
        end else begin
          state_d = ccsc_pkg::ST_OPEN_TOP;
        end
      end
      ccsc_pkg::ST_OPEN_TOP: begin
        if ((t2_q < t1_q) && (t2_q <= {1'b0, b2_q})) begin
          wr_en  = 1'b1;
          wr_row = t2_q[ROW_W-1:0];
          t2_d   = t2_q + TOP_W'(1);
        end else begin
          state_d = ccsc_pkg::ST_OPEN_BOT;
        end
      end
      ccsc_pkg::ST_OPEN_BOT: begin
        if ((b2_q > b1_q) && ({1'b0, b2_q} >= t2_q)) begin
          wr_en  = 1'b1;
          wr_row = b2_q;
          b2_d   = b2_q - ROW_W'(1);
        end else begin
          state_d = ccsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ccsc_pkg::ST_IDLE;
      end
    endcase
  end

  // working registers of the current column
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q <= column_i;
    end
    t1_q <= t1_d;
    b1_q <= b1_d;
    t2_q <= t2_d;
    b2_q <= b2_d;
  end

  // start-column store, write side
  always_ff @(posedge clk_i) begin
    if (wr_en && ({1'b0, wr_row} < RowsLimit)) begin
      mem_q[wr_row[AW-1:0]] <= col_q;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload; the store read lands directly in the span register
  always_ff @(posedge clk_i) begin
    if (load) begin
      span_row_q   <= ld_row;
      span_first_q <= ({1'b0, ld_row} < RowsLimit) ? mem_q[ld_row[AW-1:0]] : '0;
      span_last_q  <= col_q - COL_W'(1);
      last_q       <= ld_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign span_row_o      = span_row_q;
  assign span_first_o    = span_first_q;
  assign span_last_col_o = span_last_q;
  assign last_o          = last_q;

endmodule

FILE: rtl/ccsc_checker.sv
// Port-level checks for the column to span converter, bound to the top level.
// Depends on ccsc_pkg and column_to_span_converter_top.
`timescale 1ns / 1ps

module ccsc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ccsc_pkg::ROW_W-1:0]  span_row_o,
  input logic [ccsc_pkg::COL_W-1:0]  span_first_o,
  input logic [ccsc_pkg::COL_W-1:0]  span_last_col_o,
  input logic                        last_o
);

  // a stalled span holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(span_row_o) &&
      $stable(span_first_o) && $stable(span_last_col_o) && $stable(last_o))
    else $error("span changed while stalled");

  // a column transfer makes the block busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a column transfer");

  // after a non-final span the column is still in progress
  a_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> !in_ready_o)
    else $error("block idle before the final span of a column");

  // spans of one column share their last column
  a_same_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      !out_valid_o || (span_last_col_o == $past(span_last_col_o)))
    else $error("span last column changed within a column");

endmodule

bind column_to_span_converter_top ccsc_checker u_ccsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .span_row_o     (span_row_o),
  .span_first_o   (span_first_o),
  .span_last_col_o(span_last_col_o),
  .last_o         (last_o)
);
